/* rtl/bitmap_font_text_renderer_macros.svh */
// Assertion helpers used by the checker of the text renderer.
`ifndef BITMAP_FONT_TEXT_RENDERER_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfr: next-cycle check failed");

`endif

/* rtl/bfr_pkg.sv */
package bfr_pkg;

    localparam int GLYPH_STORE_DEPTH_DEF = 4096;
    localparam int BYTES_PER_PIXEL       = 4;
    localparam int PIX_SHIFT             = $clog2(BYTES_PER_PIXEL);

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // glyph index * bytes_per_glyph + row, max 255*63+32
    localparam int GADDR_W = 14;

    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;
    localparam logic [5:0] MAX_ROWS = 6'd32;
    localparam logic [3:0] MAX_WIDTH = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CURSOR = 2'd1,
        OP_DRAW   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BASE   = 3'd0,
        REG_LINE_PITCH   = 3'd1,
        REG_GLYPH_WIDTH  = 3'd2,
        REG_GLYPH_HEIGHT = 3'd3,
        REG_BYTES_GLYPH  = 3'd4,
        REG_GLYPH_COUNT  = 3'd5
    } cfg_reg_t;

    // microprogram step addresses
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_DECODE  = 4'd1,
        ST_LOAD    = 4'd2,
        ST_CURSOR  = 4'd3,
        ST_CR      = 4'd4,
        ST_LF      = 4'd5,
        ST_SETUP   = 4'd6,
        ST_BASE    = 4'd7,
        ST_COL     = 4'd8,
        ST_EMIT    = 4'd9,
        ST_ADVANCE = 4'd10
    } step_t;

    typedef enum logic [2:0] {
        CND_NEXT,       // fall through
        CND_JUMP,       // unconditional jump to target
        CND_WAIT_IN,    // hold until an input transaction
        CND_DISPATCH,   // multiway on operation and code
        CND_NO_ROWS,    // jump to target when height is zero
        CND_ROW_LOOP    // hold until the final row has been issued
    } cond_t;

    typedef struct packed {
        logic  ready;
        logic  ram_we;
        logic  set_cursor;
        logic  col_clear;
        logic  row_advance;
        logic  setup;
        logic  sum_base;
        logic  sum_col;
        logic  emit;
        logic  col_advance;
        cond_t cond;
        step_t target;
    } uword_t;

    localparam uword_t UW_NOP = '{
        ready: 1'b0, ram_we: 1'b0, set_cursor: 1'b0, col_clear: 1'b0,
        row_advance: 1'b0, setup: 1'b0, sum_base: 1'b0, sum_col: 1'b0,
        emit: 1'b0, col_advance: 1'b0, cond: CND_NEXT, target: ST_IDLE
    };

    // microcode store
    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        w = UW_NOP;
        unique case (pc)
            ST_IDLE: begin
                w.ready = 1'b1;
                w.cond  = CND_WAIT_IN;
            end
            ST_DECODE: w.cond = CND_DISPATCH;
            ST_LOAD: begin
                w.ram_we = 1'b1;
                w.cond   = CND_JUMP;
            end
            ST_CURSOR: begin
                w.set_cursor = 1'b1;
                w.cond       = CND_JUMP;
            end
            ST_CR: begin
                w.col_clear = 1'b1;
                w.cond      = CND_JUMP;
            end
            ST_LF: begin
                w.col_clear   = 1'b1;
                w.row_advance = 1'b1;
                w.cond        = CND_JUMP;
            end
            ST_SETUP: begin
                w.setup  = 1'b1;
                w.cond   = CND_NO_ROWS;
                w.target = ST_ADVANCE;
            end
            ST_BASE: w.sum_base = 1'b1;
            ST_COL:  w.sum_col = 1'b1;
            ST_EMIT: begin
                w.emit = 1'b1;
                w.cond = CND_ROW_LOOP;
            end
            ST_ADVANCE: begin
                w.col_advance = 1'b1;
                w.cond        = CND_JUMP;
            end
            default: w.cond = CND_JUMP;
        endcase
        return w;
    endfunction

endpackage

/* rtl/bfr_ram.sv */
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bitmap_font_text_renderer.sv */
// Sequence: an accepted draw item passes through decode, setup, base sum and column sum
// before its first row is issued, then one row per cycle while m_axis_tready is high;
// a new item is accepted only once the sequencer is back in idle.
// Throughput: one glyph row per cycle unless stalled, set by the single store read port.
// Reset (aresetn low, synchronous): cursor at 0,0, registers at their defaults, no result
// pending. The glyph store is not cleared; GLYPH_STORE_DEPTH must be a power of two.
module bitmap_font_text_renderer
    import bfr_pkg::*;
#(
    parameter int GLYPH_STORE_DEPTH = GLYPH_STORE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // tuser: operation[1:0]
    // tdata: start_x[15:0], start_y[31:16], char_code[39:32], font_index[51:40],
    //        font_byte[59:52], zero fill[63:60]
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    // tdata: row_address[31:0], row_bits[39:32]; tlast: last_row
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int AW = $clog2(GLYPH_STORE_DEPTH);

    logic [31:0] frame_base_reg;
    logic [15:0] line_pitch_reg;
    logic [3:0]  glyph_width_reg;
    logic [5:0]  glyph_height_reg;
    logic [5:0]  bytes_glyph_reg;
    logic [8:0]  glyph_count_reg;

    step_t       pc_reg, pc_next;
    uword_t      ctrl;

    op_t         op_reg;
    logic [15:0] start_x_reg;
    logic [15:0] start_y_reg;
    logic [7:0]  code_reg;
    logic [11:0] font_index_reg;
    logic [7:0]  font_byte_reg;

    logic [15:0] cursor_col_reg;
    logic [15:0] cursor_row_reg;
    logic [31:0] prod_reg;
    logic [31:0] addr_reg;
    logic [GADDR_W-1:0] gbase_reg;
    logic [GADDR_W-1:0] gaddr_reg;
    logic [5:0]  rows_left_reg;

    logic        m_valid_reg;
    logic [31:0] m_addr_reg;
    logic [7:0]  m_bits_reg;
    logic        m_last_reg;

    logic        in_fire;
    logic        out_free;
    logic        emit_fire;
    logic        last_issue;
    logic [5:0]  eff_height;
    logic [3:0]  eff_width;
    logic [7:0]  glyph;
    step_t       dispatch;
    step_t       pc_inc;

    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign ctrl       = ucode(pc_reg);
    assign in_fire    = s_axis_tvalid & ctrl.ready;
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign emit_fire  = ctrl.emit & out_free;
    assign last_issue = (rows_left_reg == 6'd1);

    assign eff_height = (glyph_height_reg > MAX_ROWS) ? MAX_ROWS : glyph_height_reg;
    assign eff_width  = (glyph_width_reg == 4'd0)     ? 4'd1 :
                        (glyph_width_reg > MAX_WIDTH) ? MAX_WIDTH : glyph_width_reg;
    assign glyph      = ({1'b0, code_reg} < glyph_count_reg) ? code_reg : 8'd0;

    always_comb begin
        unique case (op_reg)
            OP_LOAD:   dispatch = ST_LOAD;
            OP_CURSOR: dispatch = ST_CURSOR;
            OP_DRAW: begin
                if (code_reg == CODE_CR) begin
                    dispatch = ST_CR;
                end else if (code_reg == CODE_LF) begin
                    dispatch = ST_LF;
                end else begin
                    dispatch = ST_SETUP;
                end
            end
            default:   dispatch = ST_IDLE;
        endcase
    end

    assign pc_inc = step_t'(4'(pc_reg + 4'd1));

    always_comb begin
        unique case (ctrl.cond)
            CND_NEXT:     pc_next = pc_inc;
            CND_JUMP:     pc_next = ctrl.target;
            CND_WAIT_IN:  pc_next = in_fire ? pc_inc : pc_reg;
            CND_DISPATCH: pc_next = dispatch;
            CND_NO_ROWS:  pc_next = (eff_height == 6'd0) ? ctrl.target : pc_inc;
            CND_ROW_LOOP: pc_next = (emit_fire && last_issue) ? pc_inc : pc_reg;
            default:      pc_next = ST_IDLE;
        endcase
    end

    // first row is read while the address sum finishes, later rows as each one leaves
    assign ram_re    = ctrl.sum_col | emit_fire;
    assign ram_raddr = ctrl.sum_col ? AW'(gbase_reg) : AW'(gaddr_reg);

    bfr_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_STORE_DEPTH)
    ) u_glyph_store (
        .clk   (aclk),
        .we    (ctrl.ram_we),
        .waddr (AW'(font_index_reg)),
        .wdata (font_byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg           <= ST_IDLE;
            frame_base_reg   <= 32'd0;
            line_pitch_reg   <= 16'd4096;
            glyph_width_reg  <= 4'd8;
            glyph_height_reg <= 6'd16;
            bytes_glyph_reg  <= 6'd16;
            glyph_count_reg  <= 9'd256;
            cursor_col_reg   <= 16'd0;
            cursor_row_reg   <= 16'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            pc_reg <= pc_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_BASE:   frame_base_reg   <= cfg_data;
                    REG_LINE_PITCH:   line_pitch_reg   <= cfg_data[15:0];
                    REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[3:0];
                    REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[5:0];
                    REG_BYTES_GLYPH:  bytes_glyph_reg  <= cfg_data[5:0];
                    REG_GLYPH_COUNT:  glyph_count_reg  <= cfg_data[8:0];
                    default: ;
                endcase
            end

            if (ctrl.set_cursor) begin
                cursor_col_reg <= start_x_reg;
                cursor_row_reg <= start_y_reg;
            end else if (ctrl.col_clear) begin
                cursor_col_reg <= 16'd0;
            end else if (ctrl.col_advance) begin
                cursor_col_reg <= cursor_col_reg + 16'(eff_width) + 16'd1;
            end
            if (ctrl.row_advance) begin
                cursor_row_reg <= cursor_row_reg + 16'(eff_height);
            end

            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath payload, no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg         <= op_t'(s_axis_tuser);
            start_x_reg    <= s_axis_tdata[15:0];
            start_y_reg    <= s_axis_tdata[31:16];
            code_reg       <= s_axis_tdata[39:32];
            font_index_reg <= s_axis_tdata[51:40];
            font_byte_reg  <= s_axis_tdata[59:52];
        end
        if (ctrl.setup) begin
            prod_reg      <= cursor_row_reg * line_pitch_reg;
            gbase_reg     <= glyph * bytes_glyph_reg;
            rows_left_reg <= eff_height;
        end
        if (ctrl.sum_base) begin
            addr_reg <= prod_reg + frame_base_reg;
        end
        if (ctrl.sum_col) begin
            addr_reg  <= addr_reg + (32'(cursor_col_reg) << PIX_SHIFT);
            gaddr_reg <= gbase_reg + GADDR_W'(1);
        end
        if (emit_fire) begin
            m_addr_reg    <= addr_reg;
            m_bits_reg    <= ram_rdata;
            m_last_reg    <= last_issue;
            addr_reg      <= addr_reg + 32'(line_pitch_reg);
            gaddr_reg     <= gaddr_reg + GADDR_W'(1);
            rows_left_reg <= rows_left_reg - 6'd1;
        end
    end

    assign s_axis_tready = ctrl.ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_bits_reg, m_addr_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

/* rtl/bfr_checker.sv */
`include "bitmap_font_text_renderer_macros.svh"

module bfr_checker
    import bfr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // a stalled result transaction keeps its payload
    `BFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // one item at a time: input closes right after a transaction
    `BFR_ASSERT_NEXT(a_in_single, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // mid-glyph rows mean the sequencer is still busy with that glyph
    `BFR_ASSERT_IMPL(a_busy_mid_glyph, aclk, aresetn, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // after a non-final row leaves, the next row is still owed
    `BFR_ASSERT_NEXT(a_row_owed, aclk, aresetn, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready)

endmodule

bind bitmap_font_text_renderer bfr_checker u_bfr_checker (.*);
